[design/pif_pkg.sv]
package pif_pkg;

    localparam int MAX_INTERVALS_DEF = 4096;
    localparam int POS_W             = 63;
    localparam int IDX_W             = 12;
    localparam int FUNC_W            = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_FILTER = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef struct packed {
        logic [POS_W-1:0] iv_start;
        logic [POS_W-1:0] iv_end;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] posting;
        logic [IDX_W-1:0] index;
    } res_t;

endpackage

[design/pif_ram.sv]
module pif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/pif_ctrl.sv]
module pif_ctrl #(
    parameter int MAX_INTERVALS = pif_pkg::MAX_INTERVALS_DEF,
    localparam int AW = $clog2(MAX_INTERVALS),
    localparam int CW = AW + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pif_pkg::FUNC_W-1:0]  func,
    input  logic [pif_pkg::POS_W-1:0]   position,
    input  logic [pif_pkg::POS_W-1:0]   interval_end,
    input  logic                        list_end,
    input  logic                        out_free,
    output pif_pkg::res_t               res,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output pif_pkg::entry_t             wr_data,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  pif_pkg::entry_t             rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                cur_reg, cur_next;
    logic                         past_reg, past_next;
    logic [pif_pkg::POS_W-1:0]    last_end_reg, last_end_next;
    logic [pif_pkg::POS_W-1:0]    post_reg, post_next;
    logic                         last_reg, last_next;

    logic                         accept;
    logic                         full;
    logic [CW-1:0]                cur_p1;
    logic                         at_last;
    logic                         finish;
    logic                         keep;
    logic [31:0]                  cur_w;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CW'(MAX_INTERVALS));
    assign cur_p1   = {1'b0, cur_reg} + CW'(1);
    assign at_last  = (cur_p1 >= count_reg);
    assign cur_w    = 32'(cur_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        past_next     = past_reg;
        last_end_next = last_end_reg;
        post_next     = post_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = '{iv_start: position, iv_end: interval_end};
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        finish        = 1'b0;
        keep          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (pif_pkg::func_t'(func))
                        pif_pkg::FUNC_APPEND:
                        begin
                            if (!full)
                            begin
                                wr_en         = 1'b1;
                                count_next    = count_reg + CW'(1);
                                last_end_next = interval_end;
                            end
                        end
                        pif_pkg::FUNC_FILTER:
                        begin
                            post_next = position;
                            last_next = list_end;
                            if (count_reg == '0 || past_reg || {1'b0, cur_reg} >= count_reg)
                            begin
                                if (list_end)
                                begin
                                    cur_next  = '0;
                                    past_next = 1'b0;
                                end
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cur_reg;
                                state_next = ST_LOOK;
                            end
                        end
                        pif_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                            cur_next   = '0;
                            past_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (post_reg > rd_data.iv_end)
                begin
                    if (post_reg > last_end_reg || at_last)
                    begin
                        past_next = 1'b1;
                        finish    = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cur_p1[AW-1:0];
                        cur_next   = cur_p1[AW-1:0];
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    keep   = (post_reg >= rd_data.iv_start);
                    finish = !keep || out_free;
                end
            end
            ST_SCAN:
            begin
                if (!at_last && rd_data.iv_end < post_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cur_p1[AW-1:0];
                    cur_next = cur_p1[AW-1:0];
                end
                else
                begin
                    keep   = (post_reg >= rd_data.iv_start) && (post_reg <= rd_data.iv_end);
                    finish = !keep || out_free;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = ST_IDLE;
            if (last_reg)
            begin
                cur_next  = '0;
                past_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.valid   = finish && keep;
        res.posting = post_reg;
        res.index   = cur_w[pif_pkg::IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cur_reg   <= '0;
            past_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            past_reg  <= past_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_end_reg <= last_end_next;
        post_reg     <= post_next;
    end

    a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cur_reg} < count_reg) || (count_reg == '0 && cur_reg == '0))
        else $error("interval pointer outside loaded table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("interval count above table depth");

    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result issued into occupied output slot");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en && state_reg == ST_IDLE)
        else $error("table write overlaps a search read");

    a_look_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && state_next == ST_LOOK) |=> $past(rd_en))
        else $error("search entered without a table read");

endmodule

[design/posting_interval_filter_unit.sv]
// Interval filter for sorted posting lists. Intervals are appended one beat at a
// time into a table of MAX_INTERVALS entries (start/end in one single-port-write,
// registered-read RAM); postings are then filtered against the interval under a
// forward-only pointer, and a kept posting leaves with the index of its interval.
// Append, clear and no-op beats are handled as they are accepted. A posting is
// settled on acceptance when the table is empty or the list is already past its
// last interval; otherwise the entry under the pointer is read (ST_LOOK) and, if
// the posting lies beyond it, the pointer advances with one RAM read per interval
// (ST_SCAN). A kept posting is also held while the output register is occupied.
module posting_interval_filter_unit #(
    parameter int MAX_INTERVALS = pif_pkg::MAX_INTERVALS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pif_pkg::FUNC_W-1:0]  func,
    input  logic [pif_pkg::POS_W-1:0]   position,
    input  logic [pif_pkg::POS_W-1:0]   interval_end,
    input  logic                        list_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pif_pkg::POS_W-1:0]   kept_posting,
    output logic [pif_pkg::IDX_W-1:0]   interval_index
);

    localparam int AW = $clog2(MAX_INTERVALS);

    logic                       out_valid_reg;
    logic [pif_pkg::POS_W-1:0]  kept_posting_reg;
    logic [pif_pkg::IDX_W-1:0]  interval_index_reg;
    logic                       out_free;
    pif_pkg::res_t              res;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    pif_pkg::entry_t            wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    pif_pkg::entry_t            rd_data;

    assign out_free = !out_valid_reg || out_ready;

    pif_ram #(
        .WIDTH ($bits(pif_pkg::entry_t)),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pif_ctrl #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .position     (position),
        .interval_end (interval_end),
        .list_end     (list_end),
        .out_free     (out_free),
        .res          (res),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            kept_posting_reg   <= res.posting;
            interval_index_reg <= res.index;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kept_posting   = kept_posting_reg;
    assign interval_index = interval_index_reg;

endmodule

[tb/interval_filter_checker.sv]
module interval_filter_checker #(
    parameter int MAX_INTERVALS = pif_pkg::MAX_INTERVALS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [pif_pkg::FUNC_W-1:0]  func,
    input  logic [pif_pkg::POS_W-1:0]   position,
    input  logic [pif_pkg::POS_W-1:0]   interval_end,
    input  logic                        list_end,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [pif_pkg::POS_W-1:0]   kept_posting,
    input  logic [pif_pkg::IDX_W-1:0]   interval_index,
    output int                          fail_count,
    output int                          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pif_pkg::POS_W-1:0] posting;
        logic [pif_pkg::IDX_W-1:0] index;
    } kept_t;

    logic [pif_pkg::POS_W-1:0] iv_lo [MAX_INTERVALS];
    logic [pif_pkg::POS_W-1:0] iv_hi [MAX_INTERVALS];
    int unsigned               iv_count = 0;
    int unsigned               iv_ptr = 0;
    bit                        past_last = 1'b0;
    kept_t                     expected_kept [$];

    // forward-only pointer walk; pointer is committed only when it moves
    function automatic bit match_posting(logic [pif_pkg::POS_W-1:0] p,
                                         output int unsigned hit);
        int unsigned k;
        hit = 0;
        k = iv_ptr;
        if (iv_count == 0 || past_last || k >= iv_count)
            return 1'b0;
        if (p > iv_hi[k])
        begin
            if (p > iv_hi[iv_count-1] || k >= iv_count - 1)
            begin
                past_last = 1'b1;
                return 1'b0;
            end
            k++;
            while (k < iv_count - 1 && iv_hi[k] < p)
                k++;
            iv_ptr = k;
        end
        if (p < iv_lo[k] || p > iv_hi[k])
            return 1'b0;
        hit = k;
        return 1'b1;
    endfunction

    task automatic predict_beat(pif_pkg::func_t f, logic [pif_pkg::POS_W-1:0] p,
                                logic [pif_pkg::POS_W-1:0] e, logic last);
        int unsigned hit;
        kept_t       k;
        case (f)
            pif_pkg::FUNC_APPEND:
            begin
                if (iv_count < MAX_INTERVALS)
                begin
                    iv_lo[iv_count] = p;
                    iv_hi[iv_count] = e;
                    iv_count++;
                end
            end
            pif_pkg::FUNC_FILTER:
            begin
                if (match_posting(p, hit))
                begin
                    k.posting = p;
                    k.index   = hit[pif_pkg::IDX_W-1:0];
                    expected_kept.push_back(k);
                end
                if (last)
                begin
                    iv_ptr    = 0;
                    past_last = 1'b0;
                end
            end
            pif_pkg::FUNC_CLEAR:
            begin
                iv_count  = 0;
                iv_ptr    = 0;
                past_last = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kept_t exp_beat;
        if (!rst_n)
        begin
            iv_count  = 0;
            iv_ptr    = 0;
            past_last = 1'b0;
            expected_kept.delete();
            pending_count = 0;
            fail_count    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_kept.size() == 0)
                begin
                    $error("unexpected out beat: kept_posting %0d interval_index %0d",
                           kept_posting, interval_index);
                    fail_count++;
                end
                else
                begin
                    exp_beat = expected_kept.pop_front();
                    if (kept_posting !== exp_beat.posting)
                    begin
                        $error("kept_posting: expected %0d, actual %0d",
                               exp_beat.posting, kept_posting);
                        fail_count++;
                    end
                    if (interval_index !== exp_beat.index)
                    begin
                        $error("interval_index: expected %0d, actual %0d",
                               exp_beat.index, interval_index);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_beat(pif_pkg::func_t'(func), position, interval_end, list_end);
            pending_count = expected_kept.size();
        end
    end

endmodule

[tb/tb_posting_interval_filter_unit.sv]
module tb_posting_interval_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                        N_IV         = pif_pkg::MAX_INTERVALS_DEF;
    localparam logic [pif_pkg::POS_W-1:0] POS_MAX      = {pif_pkg::POS_W{1'b1}};
    localparam int                        STALL_LIMIT  = 50000;
    localparam int                        DRAIN_CYCLES = 4200;
    localparam int                        THIRD        = 213;
    localparam int                        FILL_N       = 128;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [pif_pkg::FUNC_W-1:0]   func = pif_pkg::FUNC_NOP;
    logic [pif_pkg::POS_W-1:0]    position = '0;
    logic [pif_pkg::POS_W-1:0]    interval_end = '0;
    logic                         list_end = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [pif_pkg::POS_W-1:0]    kept_posting;
    logic [pif_pkg::IDX_W-1:0]    interval_index;

    int fail_count;
    int pending_count;
    int send_idle_pct = 34;
    int recv_idle_pct = 45;
    int sent_items = 0;
    int stall_cycles = 0;

    // intervals as sent, used only to aim postings
    logic [63:0] tbl_lo [$];
    logic [63:0] tbl_hi [$];

    posting_interval_filter_unit #(.MAX_INTERVALS(N_IV)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .position       (position),
        .interval_end   (interval_end),
        .list_end       (list_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kept_posting   (kept_posting),
        .interval_index (interval_index)
    );

    interval_filter_checker #(.MAX_INTERVALS(N_IV)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .position       (position),
        .interval_end   (interval_end),
        .list_end       (list_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kept_posting   (kept_posting),
        .interval_index (interval_index),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[posting_interval_filter_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [pif_pkg::POS_W-1:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[pif_pkg::POS_W-1:0];
    endfunction

    function automatic logic rand_bit();
        logic [31:0] r;
        r = $urandom;
        return r[0];
    endfunction

    function automatic logic [63:0] rand_below(logic [63:0] lim);
        if (lim == 0)
            return 64'd0;
        return {$urandom, $urandom} % lim;
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(pif_pkg::func_t f, logic [pif_pkg::POS_W-1:0] p,
                             logic [pif_pkg::POS_W-1:0] e, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        position     <= p;
        interval_end <= e;
        list_end     <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (f != pif_pkg::FUNC_NOP)
            sent_items++;
        if (f == pif_pkg::FUNC_APPEND && tbl_lo.size() < N_IV)
        begin
            tbl_lo.push_back({1'b0, p});
            tbl_hi.push_back({1'b0, e});
        end
        else if (f == pif_pkg::FUNC_CLEAR)
        begin
            tbl_lo.delete();
            tbl_hi.delete();
        end
    endtask

    task automatic load_sorted(int n, int span_bits);
        logic [63:0] unit;
        logic [63:0] at;
        logic [63:0] lo;
        logic [63:0] hi;
        unit = 64'd1 << span_bits;
        at   = rand_below(unit * 4);
        for (int i = 0; i < n; i++)
        begin
            lo = at + rand_below(unit);
            hi = lo + rand_below(unit);
            if (hi > {1'b0, POS_MAX})
                break;
            send_beat(pif_pkg::FUNC_APPEND, lo[pif_pkg::POS_W-1:0], hi[pif_pkg::POS_W-1:0],
                      rand_bit());
            at = hi + 1;
        end
        if ($urandom_range(9) == 0 && at <= {1'b0, POS_MAX})
            send_beat(pif_pkg::FUNC_APPEND, at[pif_pkg::POS_W-1:0], POS_MAX, 1'b0);
    endtask

    // mostly ascending postings: inside intervals, in gaps, past the last end
    task automatic run_list(int m, logic closed);
        int          j;
        int          n;
        int          kind;
        logic [63:0] p;
        logic [63:0] floor_v;
        j = 0;
        n = tbl_lo.size();
        for (int i = 0; i < m; i++)
        begin
            kind = $urandom_range(99);
            if (n == 0 || kind >= 95)
                p = {1'b0, rand63()};
            else if (kind < 70)
            begin
                j += $urandom_range(0, 2);
                if (j >= n)
                    j = n - 1;
                p = tbl_lo[j] + rand_below(tbl_hi[j] - tbl_lo[j] + 1);
            end
            else if (kind < 85)
            begin
                j += $urandom_range(0, 1);
                if (j >= n)
                    j = n - 1;
                floor_v = (j > 0) ? tbl_hi[j-1] + 1 : 64'd0;
                p = (floor_v < tbl_lo[j]) ? floor_v + rand_below(tbl_lo[j] - floor_v)
                                          : tbl_lo[j];
            end
            else if (tbl_hi[n-1] < {1'b0, POS_MAX})
                p = tbl_hi[n-1] + 1 + rand_below({1'b0, POS_MAX} - tbl_hi[n-1]);
            else
                p = {1'b0, rand63()};
            send_beat(pif_pkg::FUNC_FILTER, p[pif_pkg::POS_W-1:0], rand63(),
                      closed && (i == m - 1));
        end
    endtask

    task automatic fill_table();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] p;
        int          j;
        send_beat(pif_pkg::FUNC_CLEAR, rand63(), rand63(), 1'b0);
        for (int i = 0; i < FILL_N; i++)
        begin
            lo = (64'(i) << 51) + rand_below(64'd1 << 49);
            hi = (i == FILL_N - 1) ? {1'b0, POS_MAX} : lo + rand_below(64'd1 << 49);
            send_beat(pif_pkg::FUNC_APPEND, lo[pif_pkg::POS_W-1:0], hi[pif_pkg::POS_W-1:0],
                      rand_bit());
        end
        j = $urandom_range(0, 3);
        while (j < FILL_N)
        begin
            p = tbl_lo[j] + rand_below(tbl_hi[j] - tbl_lo[j] + 1);
            send_beat(pif_pkg::FUNC_FILTER, p[pif_pkg::POS_W-1:0], rand63(), 1'b0);
            j += $urandom_range(1, 16);
        end
        send_beat(pif_pkg::FUNC_FILTER, POS_MAX, rand63(), 1'b1);
        // one jump from the first interval to the last
        send_beat(pif_pkg::FUNC_FILTER, tbl_lo[FILL_N-1][pif_pkg::POS_W-1:0], rand63(), 1'b1);
        send_beat(pif_pkg::FUNC_CLEAR, rand63(), rand63(), 1'b0);
    endtask

    task automatic random_episode();
        int kind;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            if ($urandom_range(3) != 0)
                send_beat(pif_pkg::FUNC_CLEAR, rand63(), rand63(), rand_bit());
            load_sorted(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                        $urandom_range(0, 56));
            repeat ($urandom_range(1, 3))
                run_list($urandom_range(1, 20), 1'b1);
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 6))
                send_beat(pif_pkg::func_t'($urandom_range(0, 3)), rand63(), rand63(),
                          rand_bit());
        end
        else
            run_list($urandom_range(1, 8), rand_bit());
    endtask

    initial
    begin
        int base;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, nop, then three intervals with postings in and between them
        send_beat(pif_pkg::FUNC_FILTER, '0, POS_MAX, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, POS_MAX, '0, 1'b1);
        send_beat(pif_pkg::FUNC_NOP, POS_MAX, POS_MAX, 1'b1);
        send_beat(pif_pkg::FUNC_APPEND, '0, '0, 1'b0);
        send_beat(pif_pkg::FUNC_APPEND, 63'd10, 63'd20, 1'b1);
        send_beat(pif_pkg::FUNC_APPEND, POS_MAX - 63'd100, POS_MAX, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, '0, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd5, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd15, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd3, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, POS_MAX, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd25, '0, 1'b1);
        // past the last interval, then list end on a dropped posting
        send_beat(pif_pkg::FUNC_CLEAR, '0, '0, 1'b1);
        send_beat(pif_pkg::FUNC_APPEND, 63'd100, 63'd200, 1'b0);
        send_beat(pif_pkg::FUNC_APPEND, 63'd300, 63'd400, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd150, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd500, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd350, '0, 1'b1);
        send_beat(pif_pkg::FUNC_FILTER, 63'd350, '0, 1'b0);
        // append mid-list, then an unsorted table
        send_beat(pif_pkg::FUNC_APPEND, 63'd500, 63'd600, 1'b1);
        send_beat(pif_pkg::FUNC_FILTER, 63'd550, '0, 1'b1);
        send_beat(pif_pkg::FUNC_APPEND, 63'd50, 63'd60, 1'b0);
        send_beat(pif_pkg::FUNC_APPEND, 63'd700, 63'd900, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd450, '0, 1'b0);
        send_beat(pif_pkg::FUNC_FILTER, 63'd800, '0, 1'b1);

        base = sent_items;
        while (sent_items - base < THIRD)
            random_episode();

        send_idle_pct = 45;
        recv_idle_pct = 34;
        fill_table();
        base = sent_items;
        while (sent_items - base < THIRD)
            random_episode();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        base = sent_items;
        while (sent_items - base < THIRD)
            random_episode();

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("[posting_interval_filter_unit] OK");
        else
        begin
            if (pending_count != 0)
                $error("%0d kept postings never arrived", pending_count);
            $display("[posting_interval_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
